/* design/q2e_pkg.sv */
// shared types, constants and the arctangent table for the quaternion to euler unit
package q2e_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef logic signed [33:0] t_val;

    typedef struct packed {
        t_val        yaw_y;
        t_val        yaw_x;
        t_val        roll_y;
        t_val        roll_x;
        t_val        num;
        logic [32:0] norm;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQMUL,
        ST_SQRT,
        ST_CLOAD,
        ST_CORD,
        ST_CONV1,
        ST_CONV2
    } t_state;

    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [28:0] DEG_FACTOR  = 29'sd240315917;
    localparam int                 MAX_STEPS   = 24;
    localparam logic [4:0]         DIV_LAST    = 5'd29;
    localparam logic [4:0]         SQRT_LAST   = 5'd30;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775852;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

/* design/q2e_front.sv */
// front end: takes quaternions, forms products and the atan2 and arcsine operands
module q2e_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic signed [15:0]        i_quat_real,
    input  logic signed [15:0]        i_quat_i,
    input  logic signed [15:0]        i_quat_j,
    input  logic signed [15:0]        i_quat_k,
    input  logic [q2e_pkg::QAW:0]     i_q_count,
    output logic                      busy,
    output logic                      o_push,
    output q2e_pkg::t_entry           o_entry
);
    import q2e_pkg::*;

    logic                     r_v1, r_v2;
    logic signed [15:0]       r_qr, r_qi, r_qj, r_qk;
    logic signed [31:0]       r_sr, r_si, r_sj, r_sk;
    logic signed [31:0]       r_pij, r_pkr, r_pjk, r_pir, r_pjr, r_pik;
    logic [QAW+1:0]           occ;
    logic                     accept;

    assign occ    = {1'b0, i_q_count} + (QAW+2)'(r_v1) + (QAW+2)'(r_v2);
    assign busy   = occ >= (QAW+2)'(QDEPTH);
    assign accept = start & ~busy;
    assign o_push = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_qr <= i_quat_real;
            r_qi <= i_quat_i;
            r_qj <= i_quat_j;
            r_qk <= i_quat_k;
        end
        if (r_v1) begin
            r_sr  <= r_qr * r_qr;
            r_si  <= r_qi * r_qi;
            r_sj  <= r_qj * r_qj;
            r_sk  <= r_qk * r_qk;
            r_pij <= r_qi * r_qj;
            r_pkr <= r_qk * r_qr;
            r_pjk <= r_qj * r_qk;
            r_pir <= r_qi * r_qr;
            r_pjr <= r_qj * r_qr;
            r_pik <= r_qi * r_qk;
        end
    end

    always_comb begin
        o_entry.yaw_y  = (34'(r_pij) + 34'(r_pkr)) <<< 1;
        o_entry.yaw_x  = 34'(r_si) - 34'(r_sj) - 34'(r_sk) + 34'(r_sr);
        o_entry.roll_y = (34'(r_pjk) + 34'(r_pir)) <<< 1;
        o_entry.roll_x = 34'(r_sk) + 34'(r_sr) - 34'(r_si) - 34'(r_sj);
        o_entry.num    = (34'(r_pjr) - 34'(r_pik)) <<< 1;
        o_entry.norm   = 33'($unsigned(r_sr)) + 33'($unsigned(r_si))
                       + 33'($unsigned(r_sj)) + 33'($unsigned(r_sk));
    end

endmodule

/* design/q2e_queue.sv */
// short queue of prepared operands between front and back
module q2e_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  q2e_pkg::t_entry       i_entry,
    input  logic                  i_pop,
    output q2e_pkg::t_entry       o_entry,
    output logic                  o_empty,
    output logic [q2e_pkg::QAW:0] o_count
);
    import q2e_pkg::*;

    t_entry           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;

    assign o_entry = r_mem[r_rp];
    assign o_empty = r_cnt == '0;
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

endmodule

/* design/q2e_cordic.sv */
// one vectoring cordic lane producing an atan2 angle in radians q.30
module q2e_cordic (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_step,
    input  logic [4:0]         i_idx,
    input  logic signed [39:0] i_y,
    input  logic signed [39:0] i_x,
    output logic signed [33:0] o_z
);
    import q2e_pkg::*;

    logic signed [39:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic               r_hold;
    logic signed [39:0] dx, dy;
    logic signed [33:0] da;

    assign o_z = r_z;
    assign dx  = r_y >>> i_idx;
    assign dy  = r_x >>> i_idx;
    assign da  = signed'(34'(atan_q30(i_idx)));

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (i_y == '0) begin
                r_hold <= 1'b1;
                r_z    <= (i_x >= 0) ? '0 : PI_Q30;
                r_x    <= i_x;
                r_y    <= i_y;
            end else if (i_x == '0) begin
                r_hold <= 1'b1;
                r_z    <= (i_y > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
                r_x    <= i_x;
                r_y    <= i_y;
            end else if (i_x < 0) begin
                r_hold <= 1'b0;
                r_z    <= (i_y > 0) ? PI_Q30 : -PI_Q30;
                r_x    <= -i_x;
                r_y    <= -i_y;
            end else begin
                r_hold <= 1'b0;
                r_z    <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
            end
        end else if (i_step && !r_hold) begin
            if (r_y > 0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + da;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - da;
            end
        end
    end

endmodule

/* design/q2e_back.sv */
// back end: arcsine operand by division and square root, three cordic lanes, unit scaling
module q2e_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  q2e_pkg::t_entry    i_entry,
    input  logic               i_degrees,
    output logic               o_pop,
    output logic               o_valid,
    output logic signed [15:0] o_yaw,
    output logic signed [15:0] o_pitch,
    output logic signed [15:0] o_roll,
    output logic               o_invalid
);
    import q2e_pkg::*;

    localparam int         NSTEPS    = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam logic [4:0] CORD_LAST = 5'(NSTEPS - 1);

    t_state             r_state, n_state;
    logic [4:0]         r_cnt;
    t_val               r_yy, r_yx, r_ry, r_rx;
    logic               r_neg, r_sat, r_inv;
    logic [32:0]        r_norm;
    logic [34:0]        r_rem;
    logic [29:0]        r_q;
    logic [30:0]        r_mag;
    logic [60:0]        r_rad, r_res, r_bit;
    logic               load, step;
    logic               r_valid;
    logic signed [15:0] r_out [3];
    logic signed [33:0] z [3];
    logic signed [45:0] r_ph [3];
    logic [44:0]        r_pl [3];
    logic signed [33:0] r_zc [3];
    logic signed [39:0] pitch_y;
    logic [32:0]        num_mag;
    logic [34:0]        rem2;
    logic [60:0]        trial;
    logic signed [15:0] conv [3];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (!i_empty) n_state = (i_entry.norm == '0) ? ST_CONV1 : ST_DIV;
            ST_DIV:   if (r_cnt == DIV_LAST) n_state = ST_SQMUL;
            ST_SQMUL: n_state = ST_SQRT;
            ST_SQRT:  if (r_cnt == SQRT_LAST) n_state = ST_CLOAD;
            ST_CLOAD: n_state = ST_CORD;
            ST_CORD:  if (r_cnt == CORD_LAST) n_state = ST_CONV1;
            ST_CONV1: n_state = ST_CONV2;
            ST_CONV2: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == ST_IDLE) && !i_empty;
        load  = r_state == ST_CLOAD;
        step  = r_state == ST_CORD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state != n_state) ? 5'd0 : r_cnt + 5'd1;
            r_valid <= r_state == ST_CONV2;
        end
    end

    assign num_mag = i_entry.num[33] ? 33'(-i_entry.num) : 33'(i_entry.num);
    assign rem2    = {r_rem[33:0], 1'b0};
    assign trial   = r_res + r_bit;
    assign pitch_y = r_neg ? -40'(signed'({1'b0, r_mag})) : 40'(signed'({1'b0, r_mag}));

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_yy   <= i_entry.yaw_y;
                r_yx   <= i_entry.yaw_x;
                r_ry   <= i_entry.roll_y;
                r_rx   <= i_entry.roll_x;
                r_neg  <= i_entry.num[33];
                r_norm <= i_entry.norm;
                r_inv  <= i_entry.norm == '0;
                r_sat  <= num_mag >= i_entry.norm;
                r_rem  <= 35'(num_mag);
                r_q    <= '0;
            end
            ST_DIV: begin
                if (rem2 >= 35'(r_norm)) begin
                    r_rem <= rem2 - 35'(r_norm);
                    r_q   <= {r_q[28:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_q   <= {r_q[28:0], 1'b0};
                end
                if (r_cnt == DIV_LAST) r_mag <= '0;
            end
            ST_SQMUL: begin
                r_mag <= r_sat ? 31'h4000_0000 : {1'b0, r_q};
                r_rad <= (61'd1 << 60) - 61'((r_sat ? 31'h4000_0000 : {1'b0, r_q})
                       * (r_sat ? 31'h4000_0000 : {1'b0, r_q}));
                r_res <= '0;
                r_bit <= 61'd1 << 60;
            end
            ST_SQRT: begin
                if (r_rad >= trial) begin
                    r_rad <= r_rad - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_CONV1: begin
                for (int k = 0; k < 3; k++) begin
                    r_ph[k] <= 46'(signed'(z[k][33:17]) * DEG_FACTOR);
                    r_pl[k] <= 45'(z[k][16:0] * 28'(DEG_FACTOR));
                    r_zc[k] <= z[k];
                end
            end
            ST_CONV2: begin
                for (int k = 0; k < 3; k++) r_out[k] <= r_inv ? 16'sd0 : conv[k];
                o_invalid <= r_inv;
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [63:0] deg, rad, v;
            deg = (64'(r_ph[k]) <<< 17) + 64'(signed'({1'b0, r_pl[k]})) + (64'sd1 <<< 45);
            deg = deg >>> 46;
            rad = (64'(r_zc[k]) + 64'sd131072) >>> 18;
            v   = i_degrees ? deg : rad;
            if (v > 64'sd32767)       conv[k] = 16'sh7fff;
            else if (v < -64'sd32768) conv[k] = -16'sh8000;
            else                      conv[k] = v[15:0];
        end
    end

    q2e_cordic u_yaw (
        .i_clk(i_clk), .i_load(load), .i_step(step), .i_idx(r_cnt),
        .i_y(40'(r_yy)), .i_x(40'(r_yx)), .o_z(z[0])
    );

    q2e_cordic u_pitch (
        .i_clk(i_clk), .i_load(load), .i_step(step), .i_idx(r_cnt),
        .i_y(pitch_y), .i_x(40'(signed'({1'b0, r_res[30:0]}))), .o_z(z[1])
    );

    q2e_cordic u_roll (
        .i_clk(i_clk), .i_load(load), .i_step(step), .i_idx(r_cnt),
        .i_y(40'(r_ry)), .i_x(40'(r_rx)), .o_z(z[2])
    );

    assign o_valid = r_valid;
    assign o_yaw   = r_out[0];
    assign o_pitch = r_out[1];
    assign o_roll  = r_out[2];

endmodule

/* design/quaternion_to_euler_unit.sv */
// top level of the quaternion to zyx euler angle unit
// A quaternion (real, i, j, k, signed Q1.14) is taken on a rising edge with
// start high and busy low. The front end registers the quaternion, then its
// products, and places the sums in a four-entry queue, so new quaternions are
// taken while the back end still works on earlier ones; busy rises when the
// queue and front stages hold four items.
// The back end takes one queued item at a time: restoring division for the
// arcsine argument, a squaring step, square root, a cordic load, then
// CORDIC_STEPS (at most 24) iterations of three parallel cordic lanes, and
// unit scaling; it takes no new item before the last one is finished.
// The result shows on the o_ ports with o_result_valid high for one cycle;
// the receiver cannot stall it. A zero quaternion skips to the scaling and
// gives zero angles and o_invalid high. i_cfg_wr_en writes the unit bit (1 =
// 1/64 degree, 0 = radians Q3.12); reset sets it to degrees and empties
// queue and pipeline.
module quaternion_to_euler_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_quat_real,
    input  logic signed [15:0] i_quat_i,
    input  logic signed [15:0] i_quat_j,
    input  logic signed [15:0] i_quat_k,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    output logic               o_result_valid,
    output logic signed [15:0] o_yaw_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_roll_angle,
    output logic               o_invalid
);
    import q2e_pkg::*;

    logic         r_degrees;
    logic         push, pop, empty;
    t_entry       in_entry, out_entry;
    logic [QAW:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degrees <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_degrees <= i_cfg_wr_data;
        end
    end

    q2e_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start),
        .i_quat_real(i_quat_real), .i_quat_i(i_quat_i),
        .i_quat_j(i_quat_j), .i_quat_k(i_quat_k),
        .i_q_count(q_count), .busy(busy), .o_push(push), .o_entry(in_entry)
    );

    q2e_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_entry(in_entry),
        .i_pop(pop), .o_entry(out_entry), .o_empty(empty), .o_count(q_count)
    );

    q2e_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_entry(out_entry),
        .i_degrees(r_degrees), .o_pop(pop), .o_valid(o_result_valid),
        .o_yaw(o_yaw_angle), .o_pitch(o_pitch_angle), .o_roll(o_roll_angle),
        .o_invalid(o_invalid)
    );

endmodule
